@@ rtl/amfe_pkg.sv @@
package amfe_pkg;

  localparam int unsigned ADDR_W = 48;
  localparam int unsigned BYTE_W = 8;

  // Bytes of one report that are parsed; later bytes only close the report.
  localparam logic [BYTE_W-1:0] MAX_REPORT_BYTES = 8'd255;

  localparam int unsigned OUTQ_DEPTH = 4;
  localparam int unsigned OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
  localparam int unsigned OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

  typedef enum logic [1:0] {
    PH_LEN     = 2'd0,
    PH_TYPE    = 2'd1,
    PH_PAYLOAD = 2'd2,
    PH_SKIP    = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    KIND_COMPANY_LO = 2'd0,
    KIND_COMPANY_HI = 2'd1,
    KIND_DATA       = 2'd2,
    KIND_STATUS     = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    STAT_FOUND     = 2'd0,
    STAT_NOT_FOUND = 2'd1,
    STAT_BAD_LEN   = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    REG_MATCH_ADDR  = 2'd0,
    REG_WANTED_TYPE = 2'd1,
    REG_MIN_PAYLOAD = 2'd2
  } reg_index_t;

  // Results produced by one parsed byte: an optional payload byte, then
  // an optional report status.
  typedef struct packed {
    logic              pay_valid;
    kind_t             pay_kind;
    logic [BYTE_W-1:0] pay_byte;
    logic              stat_valid;
    status_t           status;
  } res_t;

  typedef struct packed {
    kind_t             kind;
    logic [BYTE_W-1:0] data;
    logic [1:0]        status;
    logic              eor;
  } outq_ent_t;

endpackage

@@ rtl/amfe_parse.sv @@
module amfe_parse (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       accept,
  input  logic [amfe_pkg::ADDR_W-1:0] sender_addr,
  input  logic [amfe_pkg::BYTE_W-1:0] data_byte,
  input  logic                       first_byte,
  input  logic                       last_byte,
  input  logic [amfe_pkg::ADDR_W-1:0] match_addr,
  input  logic [amfe_pkg::BYTE_W-1:0] wanted_type,
  input  logic [amfe_pkg::BYTE_W-1:0] min_payload,
  output amfe_pkg::res_t             res
);

  amfe_pkg::phase_t            phase, phase_next;
  logic [amfe_pkg::BYTE_W-1:0] remaining, remaining_next;
  logic [1:0]                  position, position_next;
  logic                        matched, matched_next;
  logic                        found, found_next;
  logic                        bad, bad_next;
  logic [amfe_pkg::BYTE_W-1:0] seen, seen_next;

  always_comb begin
    phase_next     = phase;
    remaining_next = remaining;
    position_next  = position;
    matched_next   = matched;
    found_next     = found;
    bad_next       = bad;
    seen_next      = seen;
    res            = '0;

    // A first byte restarts the parse, even inside a report.
    if (first_byte) begin
      phase_next     = amfe_pkg::PH_LEN;
      remaining_next = '0;
      position_next  = '0;
      found_next     = 1'b0;
      bad_next       = 1'b0;
      seen_next      = '0;
      matched_next   = (sender_addr == match_addr);
    end

    if (matched_next) begin
      if (seen_next < amfe_pkg::MAX_REPORT_BYTES) begin
        seen_next = seen_next + 8'd1;
        unique case (phase_next)
          amfe_pkg::PH_LEN: begin
            // An empty structure is skipped: stay on a length byte.
            if (!found_next && data_byte != '0) begin
              remaining_next = data_byte - 8'd1;
              phase_next     = amfe_pkg::PH_TYPE;
            end
          end
          amfe_pkg::PH_TYPE: begin
            if (data_byte == wanted_type) begin
              found_next    = 1'b1;
              position_next = '0;
              if (remaining_next < min_payload) begin
                bad_next   = 1'b1;
                phase_next = amfe_pkg::PH_SKIP;
              end else if (remaining_next == '0) begin
                phase_next = amfe_pkg::PH_SKIP;
              end else begin
                phase_next = amfe_pkg::PH_PAYLOAD;
              end
            end else begin
              phase_next = (remaining_next == '0) ? amfe_pkg::PH_LEN : amfe_pkg::PH_SKIP;
            end
          end
          amfe_pkg::PH_PAYLOAD: begin
            res.pay_valid = 1'b1;
            res.pay_byte  = data_byte;
            unique case (position_next)
              2'd0:    res.pay_kind = amfe_pkg::KIND_COMPANY_LO;
              2'd1:    res.pay_kind = amfe_pkg::KIND_COMPANY_HI;
              default: res.pay_kind = amfe_pkg::KIND_DATA;
            endcase
            if (position_next != 2'd2) begin
              position_next = position_next + 2'd1;
            end
            remaining_next = remaining_next - 8'd1;
            if (remaining_next == '0) begin
              phase_next = amfe_pkg::PH_SKIP;
            end
          end
          amfe_pkg::PH_SKIP: begin
            // Once the wanted field is met, the rest of the report is ignored.
            if (!found_next) begin
              if (remaining_next != '0) begin
                remaining_next = remaining_next - 8'd1;
              end
              if (remaining_next == '0) begin
                phase_next = amfe_pkg::PH_LEN;
              end
            end
          end
          default: phase_next = amfe_pkg::PH_LEN;
        endcase
      end

      if (last_byte) begin
        if (found_next && phase_next == amfe_pkg::PH_PAYLOAD) begin
          bad_next = 1'b1;
        end
        res.stat_valid = 1'b1;
        priority if (bad_next) begin
          res.status = amfe_pkg::STAT_BAD_LEN;
        end else if (found_next) begin
          res.status = amfe_pkg::STAT_FOUND;
        end else begin
          res.status = amfe_pkg::STAT_NOT_FOUND;
        end
        matched_next   = 1'b0;
        phase_next     = amfe_pkg::PH_LEN;
        remaining_next = '0;
        position_next  = '0;
        found_next     = 1'b0;
        bad_next       = 1'b0;
        seen_next      = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= amfe_pkg::PH_LEN;
      remaining <= '0;
      position  <= '0;
      matched   <= 1'b0;
      found     <= 1'b0;
      bad       <= 1'b0;
      seen      <= '0;
    end else if (accept) begin
      phase     <= phase_next;
      remaining <= remaining_next;
      position  <= position_next;
      matched   <= matched_next;
      found     <= found_next;
      bad       <= bad_next;
      seen      <= seen_next;
    end
  end

  property p_found_clears_on_close;
    @(posedge clk) disable iff (rst)
      (accept && res.stat_valid) |=> (!found && !matched);
  endproperty
  a_found_clears_on_close: assert property (p_found_clears_on_close)
    else $error("parse state not cleared after report status");

  property p_payload_needs_found;
    @(posedge clk) disable iff (rst)
      (phase == amfe_pkg::PH_PAYLOAD) |-> (found && remaining != '0);
  endproperty
  a_payload_needs_found: assert property (p_payload_needs_found)
    else $error("payload phase without a found field");

  property p_no_result_unmatched;
    @(posedge clk) disable iff (rst)
      (!first_byte && !matched) |-> (!res.pay_valid && !res.stat_valid);
  endproperty
  a_no_result_unmatched: assert property (p_no_result_unmatched)
    else $error("result from an unmatched report");

endmodule

@@ rtl/adv_manufacturer_field_extract_unit.sv @@
// The results of an input transfer are registered into the result queue and offered in order.
// Throughput: one byte per cycle while two queue entries are free; a byte yields at most two
// results, which leave one per cycle while m_axis_tready is high, through a four-entry result queue.
// Reset (rst, synchronous, active high) empties the queue, clears the parse state and
// loads the registers with address 0, wanted type 0xFF and minimum payload 3.
module adv_manufacturer_field_extract_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,   // [47:0] sender address, [55:48] data_byte
  input  logic        s_axis_tlast,   // last_byte
  input  logic        s_axis_tuser,   // first_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] out_byte, [9:8] report_status, [15:10] zero
  output logic        m_axis_tlast,   // end_of_run
  output logic [1:0]  m_axis_tuser,   // out_kind
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [47:0] cfg_data
);

  logic [amfe_pkg::ADDR_W-1:0] match_addr;
  logic [amfe_pkg::BYTE_W-1:0] wanted_type;
  logic [amfe_pkg::BYTE_W-1:0] min_payload;

  logic                          in_accept;
  logic                          out_accept;
  amfe_pkg::res_t                res;
  amfe_pkg::outq_ent_t           outq [amfe_pkg::OUTQ_DEPTH];
  amfe_pkg::outq_ent_t           head;
  amfe_pkg::outq_ent_t           pay_ent, stat_ent;
  logic [amfe_pkg::OUTQ_PTR_W-1:0] wr_ptr, rd_ptr, stat_ptr;
  logic [amfe_pkg::OUTQ_CNT_W-1:0] count, count_next;
  logic [amfe_pkg::OUTQ_CNT_W-1:0] push_cnt;
  logic                          do_pay, do_stat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      match_addr  <= '0;
      wanted_type <= 8'hFF;
      min_payload <= 8'd3;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        amfe_pkg::REG_MATCH_ADDR:  match_addr  <= cfg_data;
        amfe_pkg::REG_WANTED_TYPE: wanted_type <= cfg_data[amfe_pkg::BYTE_W-1:0];
        amfe_pkg::REG_MIN_PAYLOAD: min_payload <= cfg_data[amfe_pkg::BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  // Room for the two results a byte can cause must be free before it is taken.
  assign s_axis_tready = (count <= amfe_pkg::OUTQ_CNT_W'(amfe_pkg::OUTQ_DEPTH - 2));
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  amfe_parse u_parse (
    .clk         (clk),
    .rst         (rst),
    .accept      (in_accept),
    .sender_addr (s_axis_tdata[47:0]),
    .data_byte   (s_axis_tdata[55:48]),
    .first_byte  (s_axis_tuser),
    .last_byte   (s_axis_tlast),
    .match_addr  (match_addr),
    .wanted_type (wanted_type),
    .min_payload (min_payload),
    .res         (res)
  );

  assign do_pay   = in_accept && res.pay_valid;
  assign do_stat  = in_accept && res.stat_valid;
  assign push_cnt = amfe_pkg::OUTQ_CNT_W'(do_pay) + amfe_pkg::OUTQ_CNT_W'(do_stat);
  assign stat_ptr = wr_ptr + amfe_pkg::OUTQ_PTR_W'(do_pay);

  assign head          = outq[rd_ptr];
  assign m_axis_tvalid = (count != '0);
  assign out_accept    = m_axis_tvalid && m_axis_tready;
  assign m_axis_tdata  = {6'd0, head.status, head.data};
  assign m_axis_tlast  = head.eor;
  assign m_axis_tuser  = head.kind;

  always_comb begin
    pay_ent        = '0;
    pay_ent.kind   = res.pay_kind;
    pay_ent.data   = res.pay_byte;
    stat_ent       = '0;
    stat_ent.kind  = amfe_pkg::KIND_STATUS;
    stat_ent.status = res.status;
    stat_ent.eor   = 1'b1;
    count_next     = count + push_cnt - amfe_pkg::OUTQ_CNT_W'(out_accept);
  end

  always_ff @(posedge clk) begin
    if (do_pay) begin
      outq[wr_ptr] <= pay_ent;
    end
    if (do_stat) begin
      outq[stat_ptr] <= stat_ent;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + push_cnt[amfe_pkg::OUTQ_PTR_W-1:0];
      if (out_accept) begin
        rd_ptr <= rd_ptr + amfe_pkg::OUTQ_PTR_W'(1);
      end
      count <= count_next;
    end
  end

  property p_count_bound;
    @(posedge clk) disable iff (rst)
      count <= amfe_pkg::OUTQ_CNT_W'(amfe_pkg::OUTQ_DEPTH);
  endproperty
  a_count_bound: assert property (p_count_bound)
    else $error("result queue overflow");

  property p_count_tracks;
    @(posedge clk) disable iff (rst)
      !$past(rst) |-> count == $past(count) + $past(push_cnt)
                               - amfe_pkg::OUTQ_CNT_W'($past(out_accept));
  endproperty
  a_count_tracks: assert property (p_count_tracks)
    else $error("result queue count lost a transfer");

  property p_status_closes;
    @(posedge clk) disable iff (rst)
      m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser == amfe_pkg::KIND_STATUS));
  endproperty
  a_status_closes: assert property (p_status_closes)
    else $error("end of run not on a status result");

  property p_status_code;
    @(posedge clk) disable iff (rst)
      m_axis_tvalid |-> m_axis_tdata[9:8] != 2'd3;
  endproperty
  a_status_code: assert property (p_status_code)
    else $error("undefined report status");

endmodule
